// ===== hdl/hvt_pkg.sv =====
// ============================================================================
// hvt_pkg: shared types and constants for the homogeneous vertex transform
// Payload structs, fixed-point constants and the quotient stage state.
// ============================================================================
package hvt_pkg;

    localparam int VW      = 32;
    localparam int FB      = 16;
    localparam int NLANE   = 4;
    localparam int QW      = VW + FB + 1;      // numerator magnitude width
    localparam int DIV_STEPS = QW;             // one quotient bit per stage

    localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
    localparam logic signed [VW-1:0] ONE  = VW'(64'sd1 <<< FB);

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_XFRM = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [1:0]        row_index;
        logic signed [31:0] comp_x;
        logic signed [31:0] comp_y;
        logic signed [31:0] comp_z;
        logic signed [31:0] comp_w;
    } t_in;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_w;
        logic               w_was_zero;
    } t_out;

    // State carried by one restoring-divide stage of one lane
    typedef struct packed {
        logic [QW-1:0] num;     // shifting numerator
        logic [QW:0]   rem;
        logic [QW-1:0] quo;
        logic          neg;
    } t_dlane;

endpackage

// ===== hdl/hvt_lane.sv =====
// ============================================================================
// hvt_lane: one matrix row dot product
// Four registered products, rounding, then a registered saturated sum.
// ============================================================================
module hvt_lane (
    input  logic                          i_clk,
    input  logic signed [hvt_pkg::VW-1:0] i_m0,
    input  logic signed [hvt_pkg::VW-1:0] i_m1,
    input  logic signed [hvt_pkg::VW-1:0] i_m2,
    input  logic signed [hvt_pkg::VW-1:0] i_m3,
    input  logic signed [hvt_pkg::VW-1:0] i_c0,
    input  logic signed [hvt_pkg::VW-1:0] i_c1,
    input  logic signed [hvt_pkg::VW-1:0] i_c2,
    input  logic signed [hvt_pkg::VW-1:0] i_c3,
    input  logic                          i_en,
    output logic signed [hvt_pkg::VW-1:0] o_sum
);
    localparam int PW = 2 * hvt_pkg::VW;

    logic signed [PW-1:0] r_p [4];
    logic signed [PW-1:0] n_p [4];
    logic signed [PW-1:0] w_s [4];
    logic signed [PW+1:0] w_acc;

    assign n_p[0] = i_m0 * i_c0;
    assign n_p[1] = i_m1 * i_c1;
    assign n_p[2] = i_m2 * i_c2;
    assign n_p[3] = i_m3 * i_c3;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 4; k++) r_p[k] <= n_p[k];
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++)
            w_s[k] = (r_p[k] + (PW'(1) <<< (hvt_pkg::FB - 1))) >>> hvt_pkg::FB;
        w_acc = (PW+2)'(w_s[0]) + (PW+2)'(w_s[1]) + (PW+2)'(w_s[2]) + (PW+2)'(w_s[3]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_acc > (PW+2)'(hvt_pkg::VMAX))      o_sum <= hvt_pkg::VMAX;
            else if (w_acc < (PW+2)'(hvt_pkg::VMIN)) o_sum <= hvt_pkg::VMIN;
            else                                     o_sum <= w_acc[hvt_pkg::VW-1:0];
        end
    end
endmodule

// ===== hdl/hvt_div.sv =====
// ============================================================================
// hvt_div: pipelined perspective divide for x, y and z
// One restoring-divide bit per stage for three lanes sharing one divisor.
// ============================================================================
module hvt_div (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic signed [hvt_pkg::VW-1:0]  i_x,
    input  logic signed [hvt_pkg::VW-1:0]  i_y,
    input  logic signed [hvt_pkg::VW-1:0]  i_z,
    input  logic signed [hvt_pkg::VW-1:0]  i_w,
    input  logic                           i_div,    // divide requested, w nonzero
    input  logic                           i_flag,
    output hvt_pkg::t_out                  o_res
);
    localparam int QW = hvt_pkg::QW;
    localparam int NS = hvt_pkg::DIV_STEPS;

    hvt_pkg::t_dlane r_st [NS+1][3];
    logic [QW-1:0]   r_dv   [NS+1];
    logic signed [hvt_pkg::VW-1:0] r_raw [NS+1][4];
    logic            r_div  [NS+1];
    logic            r_flag [NS+1];
    logic signed [hvt_pkg::VW-1:0] w_in [3];
    logic [hvt_pkg::VW:0] w_wm;

    assign w_in[0] = i_x;
    assign w_in[1] = i_y;
    assign w_in[2] = i_z;
    // widen before negating so the most negative value yields its true magnitude
    assign w_wm = i_w[hvt_pkg::VW-1] ? -{1'b1, i_w} : {1'b0, i_w};

    // stage 0: magnitudes, numerator scaled by the fraction bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 3; l++) begin
                logic [hvt_pkg::VW:0] am;
                am = w_in[l][hvt_pkg::VW-1] ? -{1'b1, w_in[l]} : {1'b0, w_in[l]};
                r_st[0][l].num <= QW'(am) << hvt_pkg::FB;
                r_st[0][l].rem <= '0;
                r_st[0][l].quo <= '0;
                r_st[0][l].neg <= w_in[l][hvt_pkg::VW-1] ^ i_w[hvt_pkg::VW-1];
            end
            r_dv[0]   <= QW'(w_wm);
            r_raw[0][0] <= i_x;
            r_raw[0][1] <= i_y;
            r_raw[0][2] <= i_z;
            r_raw[0][3] <= i_w;
            r_div[0]  <= i_div;
            r_flag[0] <= i_flag;
        end
    end

    // Long division of num by w: numerator bits enter MSB first.
    for (genvar s = 0; s < NS; s++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int l = 0; l < 3; l++) begin
                    logic [QW:0] t;
                    t = {r_st[s][l].rem[QW-1:0], r_st[s][l].num[QW-1]};
                    if (t >= {1'b0, r_dv[s]}) begin
                        r_st[s+1][l].rem <= t - {1'b0, r_dv[s]};
                        r_st[s+1][l].quo <= {r_st[s][l].quo[QW-2:0], 1'b1};
                    end else begin
                        r_st[s+1][l].rem <= t;
                        r_st[s+1][l].quo <= {r_st[s][l].quo[QW-2:0], 1'b0};
                    end
                    r_st[s+1][l].num <= {r_st[s][l].num[QW-2:0], 1'b0};
                    r_st[s+1][l].neg <= r_st[s][l].neg;
                end
                r_dv[s+1]   <= r_dv[s];
                r_raw[s+1]  <= r_raw[s];
                r_div[s+1]  <= r_div[s];
                r_flag[s+1] <= r_flag[s];
            end
        end
    end

    // round: q + (rem >= w - floor(w/2)) equals floor((n + floor(w/2))/w)
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            logic [QW+1:0] q [3];
            logic signed [QW+2:0] v [3];
            for (int l = 0; l < 3; l++) begin
                q[l] = (QW+2)'(r_st[NS][l].quo)
                     + (QW+2)'(r_st[NS][l].rem >= ((QW+1)'(r_dv[NS]) - (QW+1)'(r_dv[NS] >> 1)));
                v[l] = r_st[NS][l].neg ? -(QW+3)'(q[l]) : (QW+3)'(q[l]);
            end
            if (r_div[NS]) begin
                o_res.out_x <= (v[0] > (QW+3)'(hvt_pkg::VMAX)) ? hvt_pkg::VMAX :
                               (v[0] < (QW+3)'(hvt_pkg::VMIN)) ? hvt_pkg::VMIN : v[0][31:0];
                o_res.out_y <= (v[1] > (QW+3)'(hvt_pkg::VMAX)) ? hvt_pkg::VMAX :
                               (v[1] < (QW+3)'(hvt_pkg::VMIN)) ? hvt_pkg::VMIN : v[1][31:0];
                o_res.out_z <= (v[2] > (QW+3)'(hvt_pkg::VMAX)) ? hvt_pkg::VMAX :
                               (v[2] < (QW+3)'(hvt_pkg::VMIN)) ? hvt_pkg::VMIN : v[2][31:0];
                o_res.out_w <= hvt_pkg::ONE;
            end else begin
                o_res.out_x <= r_raw[NS][0];
                o_res.out_y <= r_raw[NS][1];
                o_res.out_z <= r_raw[NS][2];
                o_res.out_w <= r_raw[NS][3];
            end
            o_res.w_was_zero <= r_flag[NS];
        end
    end
endmodule

// ===== hdl/homogeneous_vertex_transform_core.sv =====
// ============================================================================
// homogeneous_vertex_transform_core: 4x4 transform with perspective divide
// Channel | dir | payload
// in      | in  | t_in  (load row or transform point)
// out     | out | t_out (one per transform item)
// cfg     | in  | homogenize enable, one bit
// One item per cycle while the output is not stalled. The pipe runs the
// multiply-sum, one flag stage, the bit-per-stage divide, one output stage.
// The whole pipe advances together; a stall on the output freezes it.
// Reset loads the identity matrix and clears valid bits and the enable.
// ============================================================================
module homogeneous_vertex_transform_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  hvt_pkg::t_in   i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output hvt_pkg::t_out  o_data,
    input  logic           i_cfg_we,
    input  logic           i_cfg_wdata
);
    localparam int VW  = hvt_pkg::VW;
    localparam int LAT = 5 + hvt_pkg::DIV_STEPS;

    logic signed [VW-1:0] r_mat [4][4];
    logic                 r_homog;
    logic [LAT-1:0]       r_vld;
    logic                 w_adv, w_acc;
    logic signed [VW-1:0] w_c [4];
    logic signed [VW-1:0] w_sum [4];
    logic                 r_hm1, r_hm2;
    logic signed [VW-1:0] r_s [4];
    logic                 r_div, r_flag;

    assign w_adv   = !(o_valid && i_stall);
    assign o_stall = !w_adv;
    assign w_acc   = i_valid && w_adv;
    assign o_valid = r_vld[LAT-1];

    assign w_c[0] = i_data.comp_x;
    assign w_c[1] = i_data.comp_y;
    assign w_c[2] = i_data.comp_z;
    assign w_c[3] = i_data.comp_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                    r_mat[r][c] <= (r == c) ? hvt_pkg::ONE : '0;
            r_homog <= 1'b0;
            r_vld   <= '0;
        end else begin
            if (i_cfg_we) r_homog <= i_cfg_wdata;
            if (w_acc && i_data.mode == hvt_pkg::MODE_LOAD)
                for (int c = 0; c < 4; c++) r_mat[i_data.row_index][c] <= w_c[c];
            if (w_adv)
                r_vld <= {r_vld[LAT-2:0], w_acc && i_data.mode == hvt_pkg::MODE_XFRM};
        end
    end

    for (genvar g = 0; g < hvt_pkg::NLANE; g++) begin : g_lane
        hvt_lane u_lane (
            .i_clk (i_clk),
            .i_m0  (r_mat[g][0]), .i_m1 (r_mat[g][1]),
            .i_m2  (r_mat[g][2]), .i_m3 (r_mat[g][3]),
            .i_c0  (w_c[0]), .i_c1 (w_c[1]), .i_c2 (w_c[2]), .i_c3 (w_c[3]),
            .i_en  (w_adv),
            .o_sum (w_sum[g])
        );
    end

    // merge: decide divide or pass-through from the summed w
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_hm1  <= r_homog;
            r_hm2  <= r_hm1;
            r_s    <= w_sum;
            r_div  <= r_hm2 && (w_sum[3] != '0);
            r_flag <= r_hm2 && (w_sum[3] == '0);
        end
    end

    hvt_div u_div (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_x    (r_s[0]),
        .i_y    (r_s[1]),
        .i_z    (r_s[2]),
        .i_w    (r_s[3]),
        .i_div  (r_div),
        .i_flag (r_flag),
        .o_res  (o_data)
    );
endmodule

// ===== hdl/hvt_checker.sv =====
// ============================================================================
// hvt_checker: port-level checks for the vertex transform core
// Watches handshake and result flags on the top-level ports.
// ============================================================================
module hvt_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          o_valid,
    input  logic          i_stall,
    input  logic          o_stall,
    input  hvt_pkg::t_out o_data
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data)) else $error("result dropped");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall) else $error("needless stall");
    a_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.w_was_zero |-> o_data.out_w == '0) else $error("flag with w");
endmodule

bind homogeneous_vertex_transform_core hvt_checker u_chk (
    .i_clk (i_clk), .i_rst_n (i_rst_n), .o_valid (o_valid),
    .i_stall (i_stall), .o_stall (o_stall), .o_data (o_data)
);
